### design/mcct_pkg.sv
// Shared types, constants and lookup tables for the marching-cubes cell triangulator.
// Used by every module of the block; depends on nothing else.
package mcct_pkg;

	localparam int DENS_W            = 32;
	localparam int COORD_W           = 32;
	localparam int CUBE_W            = 8;
	localparam int NTRI_W            = 3;
	localparam int SPACING_W         = 31;
	localparam int NODES_W           = 9;
	localparam int CFG_IDX_W         = 3;
	localparam int CFG_DATA_W        = 32;
	localparam int IN_DATA_W         = 288;
	localparam int OUT_DATA_W        = 288;
	localparam int GRID_NODES_MAX_DEF = 256;
	localparam int FRAC_BITS_DEF     = 16;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ISO_LEVEL = 3'd0,
		REG_ORIGIN_X  = 3'd1,
		REG_ORIGIN_Y  = 3'd2,
		REG_ORIGIN_Z  = 3'd3,
		REG_SPACING   = 3'd4,
		REG_NODES_X   = 3'd5,
		REG_NODES_Y   = 3'd6,
		REG_NODES_Z   = 3'd7
	} cfg_reg_t;

	typedef struct packed {
		logic signed [DENS_W-1:0]   iso;
		logic [2:0][COORD_W-1:0]    origin;
		logic [SPACING_W-1:0]       spacing;
		logic [2:0][NODES_W-1:0]    nodes;
	} cfg_t;

	// One queued cube that produces at least one triangle.
	typedef struct packed {
		logic [2:0][CUBE_W-1:0]     cube;
		logic [7:0][DENS_W-1:0]     dens;
		logic [7:0]                 ci;
		logic [NTRI_W-1:0]          ntri;
	} entry_t;

	// Edge end corners.
	localparam logic [2:0] EDGE_A [12] = '{3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5,
		3'd6, 3'd7, 3'd0, 3'd1, 3'd2, 3'd3};
	localparam logic [2:0] EDGE_B [12] = '{3'd1, 3'd2, 3'd3, 3'd0, 3'd5, 3'd6,
		3'd7, 3'd4, 3'd4, 3'd5, 3'd6, 3'd7};

	// Corner offset bits: bit 0 is x, bit 1 is y, bit 2 is z.
	localparam logic [2:0] CORNER_OFF [8] = '{3'b000, 3'b001, 3'b011, 3'b010,
		3'b100, 3'b101, 3'b111, 3'b110};

	// Each row: triangle count, then edge codes one per hex digit, first edge in the
	// most significant used digit.
	localparam logic [62:0] TRI_TAB [256] = '{
		{3'd0,60'h0}, {3'd1,60'h083}, {3'd1,60'h019}, {3'd2,60'h183981},
		{3'd1,60'h12A}, {3'd2,60'h08312A}, {3'd2,60'h92A029}, {3'd3,60'h2832A8A98},
		{3'd1,60'h3B2}, {3'd2,60'h0B28B0}, {3'd2,60'h19023B}, {3'd3,60'h1B219B98B},
		{3'd2,60'h3A1BA3}, {3'd3,60'h0A108A8BA}, {3'd3,60'h3903B9BA9}, {3'd2,60'h98AA8B},
		{3'd1,60'h478}, {3'd2,60'h430734}, {3'd2,60'h019847}, {3'd3,60'h419471731},
		{3'd2,60'h12A847}, {3'd3,60'h34730412A}, {3'd3,60'h92A902847},
		{3'd4,60'h2A9297273794},
		{3'd2,60'h8473B2}, {3'd3,60'hB47B24204}, {3'd3,60'h90184723B},
		{3'd4,60'h47B94B9B2921},
		{3'd3,60'h3A13BA784}, {3'd4,60'h1BA14B1047B4}, {3'd4,60'h47890B9BAB03},
		{3'd3,60'h47B4B99BA},
		{3'd1,60'h954}, {3'd2,60'h954083}, {3'd2,60'h054150}, {3'd3,60'h854835315},
		{3'd2,60'h12A954}, {3'd3,60'h30812A495}, {3'd3,60'h52A542402},
		{3'd4,60'h2A5325354348},
		{3'd2,60'h95423B}, {3'd3,60'h0B208B495}, {3'd3,60'h05401523B},
		{3'd4,60'h21525828B485},
		{3'd3,60'hA3BA13954}, {3'd4,60'h4950818A18BA}, {3'd4,60'h54050B5BAB03},
		{3'd3,60'h54858AA8B},
		{3'd2,60'h978579}, {3'd3,60'h930953573}, {3'd3,60'h078017157}, {3'd2,60'h153357},
		{3'd3,60'h978957A12}, {3'd4,60'hA12950530573}, {3'd4,60'h802825857A52},
		{3'd3,60'h2A5253357},
		{3'd3,60'h7957893B2}, {3'd4,60'h95797292027B}, {3'd4,60'h23B018178157},
		{3'd3,60'hB21B17715},
		{3'd4,60'h958857A13A3B}, {3'd5,60'h5705097B010ABA0}, {3'd5,60'hBA0B03A50807570},
		{3'd2,60'hBA57B5},
		{3'd1,60'hA65}, {3'd2,60'h0835A6}, {3'd2,60'h9015A6}, {3'd3,60'h1831985A6},
		{3'd2,60'h165261}, {3'd3,60'h165126308}, {3'd3,60'h965906026},
		{3'd4,60'h598582526328},
		{3'd2,60'h23BA65}, {3'd3,60'hB08B20A65}, {3'd3,60'h01923B5A6},
		{3'd4,60'h5A61929B298B},
		{3'd3,60'h63B653513}, {3'd4,60'h08B0B50515B6}, {3'd4,60'h3B6036065059},
		{3'd3,60'h65969BB98},
		{3'd2,60'h5A6478}, {3'd3,60'h43047365A}, {3'd3,60'h1905A6847},
		{3'd4,60'hA65197173794},
		{3'd3,60'h612651478}, {3'd4,60'h125526304347}, {3'd4,60'h847905065026},
		{3'd5,60'h739794329596269},
		{3'd3,60'h3B2784A65}, {3'd4,60'h5A647242027B}, {3'd4,60'h01947823B5A6},
		{3'd5,60'h9219B294B7B45A6},
		{3'd4,60'h8473B53515B6}, {3'd5,60'h51B5B610B7B404B}, {3'd5,60'h059065036B63847},
		{3'd4,60'h65969B4797B9},
		{3'd2,60'hA4964A}, {3'd3,60'h4A649A083}, {3'd3,60'hA01A60640},
		{3'd4,60'h83181686461A},
		{3'd3,60'h149124264}, {3'd4,60'h308129249264}, {3'd2,60'h024426},
		{3'd3,60'h832824426},
		{3'd3,60'hA49A64B23}, {3'd4,60'h08228B49A4A6}, {3'd4,60'h3B201606461A},
		{3'd5,60'h64161A48121B8B1},
		{3'd4,60'h964936913B63}, {3'd5,60'h8B1810B61914641}, {3'd3,60'h3B6360064},
		{3'd2,60'h648B68},
		{3'd3,60'h7A678A89A}, {3'd4,60'h0730A709A67A}, {3'd4,60'hA671A7178180},
		{3'd3,60'hA67A71173},
		{3'd4,60'h126168189867}, {3'd5,60'h269291679093739}, {3'd3,60'h780706602},
		{3'd2,60'h732672},
		{3'd4,60'h23BA68A89867}, {3'd5,60'h20727B09767A9A7}, {3'd5,60'h1801781A767A23B},
		{3'd4,60'hB21B17A61671},
		{3'd5,60'h896867916B63136}, {3'd2,60'h091B67}, {3'd4,60'h7807063B0B60},
		{3'd1,60'h7B6},
		{3'd1,60'h76B}, {3'd2,60'h308B76}, {3'd2,60'h019B76}, {3'd3,60'h819831B76},
		{3'd2,60'hA126B7}, {3'd3,60'h12A3086B7}, {3'd3,60'h2902A96B7},
		{3'd4,60'h6B72A3A83A98},
		{3'd2,60'h723627}, {3'd3,60'h708760620}, {3'd3,60'h276237019},
		{3'd4,60'h162186198876},
		{3'd3,60'hA76A17137}, {3'd4,60'hA7617A187108}, {3'd4,60'h03707A0A96A7},
		{3'd3,60'h76A7A88A9},
		{3'd2,60'h684B86}, {3'd3,60'h36B306046}, {3'd3,60'h86B846901},
		{3'd4,60'h946963931B36},
		{3'd3,60'h6846B82A1}, {3'd4,60'h12A30B06B046}, {3'd4,60'h4B846B0292A9},
		{3'd5,60'hA93A32943B36463},
		{3'd3,60'h823842462}, {3'd2,60'h042462}, {3'd4,60'h190234246438},
		{3'd3,60'h194142246},
		{3'd4,60'h8138618466A1}, {3'd3,60'hA10A06604}, {3'd5,60'h4634386A3039A93},
		{3'd2,60'hA946A4},
		{3'd2,60'h49576B}, {3'd3,60'h083495B76}, {3'd3,60'h50154076B},
		{3'd4,60'hB76834354315},
		{3'd3,60'h954A1276B}, {3'd4,60'h6B712A083495}, {3'd4,60'h76B54A42A402},
		{3'd5,60'h348354325A52B76},
		{3'd3,60'h723762549}, {3'd4,60'h954086062687}, {3'd4,60'h362376150540},
		{3'd5,60'h628687218485158},
		{3'd4,60'h954A16176137}, {3'd5,60'h16A176107870954}, {3'd5,60'h40A4A503A6A737A},
		{3'd4,60'h76A7A854A48A},
		{3'd3,60'h6956B9B89}, {3'd4,60'h36B063056095}, {3'd4,60'h0B805B01556B},
		{3'd3,60'h6B3635531},
		{3'd4,60'h12A95B9B8B56}, {3'd5,60'h0B306B09656912A}, {3'd5,60'hB85B56805A52025},
		{3'd4,60'h6B36352A3A53},
		{3'd4,60'h589528562382}, {3'd3,60'h956960062}, {3'd5,60'h158180568382628},
		{3'd2,60'h156216},
		{3'd5,60'h13616A386569896}, {3'd4,60'hA10A06950560}, {3'd2,60'h03856A},
		{3'd1,60'hA56},
		{3'd2,60'hB5A75B}, {3'd3,60'hB5AB75830}, {3'd3,60'h5B75AB190},
		{3'd4,60'hA75AB7981831},
		{3'd3,60'hB12B71751}, {3'd4,60'h08312717572B}, {3'd4,60'h9759279022B7},
		{3'd5,60'h75272B592328982},
		{3'd3,60'h25A235375}, {3'd4,60'h820852875A25}, {3'd4,60'h9015A35373A2},
		{3'd5,60'h982921872A25752},
		{3'd2,60'h135375}, {3'd3,60'h087071175}, {3'd3,60'h903935537}, {3'd2,60'h987597},
		{3'd3,60'h5845A8AB8}, {3'd4,60'h5045B05ABB30}, {3'd4,60'h01984A8ABA45},
		{3'd5,60'hAB4A45B34941314},
		{3'd4,60'h2512852B8458}, {3'd5,60'h04B0B345B2B151B}, {3'd5,60'h0250592B5458B85},
		{3'd2,60'h9452B3},
		{3'd4,60'h25A352345384}, {3'd3,60'h5A2524420}, {3'd5,60'h3A235A385458019},
		{3'd4,60'h5A2524192942},
		{3'd3,60'h845853351}, {3'd2,60'h045105}, {3'd4,60'h845853905035}, {3'd1,60'h945},
		{3'd3,60'h4B749B9AB}, {3'd4,60'h0834979B79AB}, {3'd4,60'h1AB1B414074B},
		{3'd5,60'h3143481A474BAB4},
		{3'd4,60'h4B79B492B912}, {3'd5,60'h9749B791B2B1083}, {3'd3,60'hB74B42240},
		{3'd4,60'hB74B42834324},
		{3'd4,60'h29A279237749}, {3'd5,60'h9A7974A27870207}, {3'd5,60'h37A3A274A1A040A},
		{3'd2,60'h1A2874},
		{3'd3,60'h491417713}, {3'd4,60'h491417081871}, {3'd2,60'h403743}, {3'd1,60'h487},
		{3'd2,60'h9A8AB8}, {3'd3,60'h30939BB9A}, {3'd3,60'h01A0A88AB}, {3'd2,60'h31AB3A},
		{3'd3,60'h12B1B99B8}, {3'd4,60'h30939B1292B9}, {3'd2,60'h02B80B}, {3'd1,60'h32B},
		{3'd3,60'h23828AA89}, {3'd2,60'h9A2092}, {3'd4,60'h23828A0181A8}, {3'd1,60'h1A2},
		{3'd2,60'h138918}, {3'd1,60'h091}, {3'd1,60'h038}, {3'd0,60'h0}
	};

	function automatic logic [NTRI_W-1:0] tri_count(input logic [7:0] ci);
		logic [62:0] row;
		row = TRI_TAB[ci];
		return row[62:60];
	endfunction

	// Edge code of vertex idx (0 .. 3*count-1) of the given case.
	function automatic logic [3:0] tri_edge(input logic [7:0] ci, input logic [3:0] idx);
		logic [62:0] row;
		logic [3:0]  pos;
		logic [59:0] sh;
		row = TRI_TAB[ci];
		pos = 4'({1'b0, row[62:60]}) * 4'd3 - 4'd1 - idx;
		sh  = row[59:0] >> {pos, 2'b00};
		return sh[3:0];
	endfunction

endpackage

### design/mcct_front.sv
// Front end: takes a cube request, checks it against the grid, forms the case index.
// Depends on mcct_pkg; feeds mcct_queue.
module mcct_front import mcct_pkg::*; #(
	parameter int GRID_NODES_MAX = GRID_NODES_MAX_DEF
) (
	input  cfg_t                  cfg,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,   // cube_x, cube_y, cube_z, density_c0..c7, pad
	input  logic                  full,
	output logic                  push,
	output entry_t                entry
);

	logic [2:0]             axis_ok;
	logic [7:0]             ci;
	logic [NTRI_W-1:0]      ntri;
	logic [NODES_W:0]       cube_p1 [3];
	logic [NODES_W-1:0]     cube_raw [3];

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			cube_raw[k] = s_tdata[NODES_W*k +: NODES_W];
			cube_p1[k]  = {2'b00, cube_raw[k][CUBE_W-1:0]} + 10'd1;
			// A cube needs both its lower and upper node inside the clamped grid.
			axis_ok[k]  = !cube_raw[k][NODES_W-1] &&
				(cube_p1[k] < {1'b0, cfg.nodes[k]}) &&
				(int'(cube_p1[k]) < GRID_NODES_MAX);
			entry.cube[k] = cube_raw[k][CUBE_W-1:0];
		end
		for (int k = 0; k < 8; k++) begin
			entry.dens[k] = s_tdata[3*NODES_W + DENS_W*k +: DENS_W];
			ci[k] = $signed(entry.dens[k]) < cfg.iso;
		end
		ntri       = tri_count(ci);
		entry.ci   = ci;
		entry.ntri = ntri;
	end

	assign s_tready = !full;
	assign push     = s_tvalid && !full && (&axis_ok) && (ntri != '0);

endmodule

### design/mcct_queue.sv
// Two-entry queue of classified cubes between the front and back ends.
// Depends on mcct_pkg for the entry type.
module mcct_queue import mcct_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  entry_t wr_entry,
	input  logic   pop,
	output logic   full,
	output logic   nonempty,
	output entry_t head
);

	entry_t     mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			count_q <= count_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_entry;
		end
	end

	assign full     = count_q == 2'd2;
	assign nonempty = count_q != 2'd0;
	assign head     = mem_q[rd_ptr_q];

endmodule

### design/mcct_back.sv
// Back end: per triangle vertex, divides for the edge fraction, maps to world space and
// saturates; holds the result register. Depends on mcct_pkg.
module mcct_back import mcct_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  cfg_t                   cfg,
	input  logic                   nonempty,
	input  entry_t                 head,
	output logic                   pop,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_DATA_W-1:0]  m_tdata,  // vert_a_x,a_y,a_z,b_x,b_y,b_z,c_x,c_y,c_z
	output logic                   m_tlast   // last_triangle
);

	localparam int GIW = CUBE_W + 1;
	localparam int GW  = GIW + FRAC_BITS;
	localparam int PHW = SPACING_W + GIW;
	localparam int PLW = SPACING_W + FRAC_BITS;
	localparam int SW  = PHW + 2;
	localparam int CW  = $clog2(FRAC_BITS);
	localparam logic [FRAC_BITS:0]    ONE    = {1'b1, {FRAC_BITS{1'b0}}};
	localparam logic signed [SW-1:0]  SAT_HI = SW'(32'h7fffffff);
	localparam logic signed [SW-1:0]  SAT_LO = -SAT_HI - SW'(1);

	typedef enum logic [2:0] {
		ST_IDLE, ST_SETUP, ST_ABS, ST_DECIDE, ST_DIV, ST_GPOS, ST_MUL, ST_ADD
	} state_t;

	state_t                   state_q;
	logic [NTRI_W-1:0]        tri_q;
	logic [1:0]               vtx_q;
	logic [1:0]               axis_q;
	logic [CW-1:0]            cnt_q;
	logic [2:0]               ca_q;
	logic [2:0]               cb_q;
	logic signed [DENS_W:0]   num_q;
	logic signed [DENS_W:0]   den_q;
	logic [DENS_W:0]          nm_q;
	logic [DENS_W:0]          dm_q;
	logic [DENS_W+1:0]        rem_q;
	logic [FRAC_BITS:0]       q_q;
	logic [GW-1:0]            g_q;
	logic [PHW-1:0]           phi_q;
	logic [PLW-1:0]           plo_q;
	logic [COORD_W-1:0]       vert_q [9];
	logic                     out_valid_q;
	logic                     emit_pending_q;

	logic [3:0]               vidx;
	logic [3:0]               edge_code;
	logic [3:0]               edge_sel;
	logic [2:0]               ca;
	logic [2:0]               cb;
	logic [DENS_W-1:0]        da;
	logic [DENS_W-1:0]        db;
	logic [DENS_W+1:0]        rem2;
	logic                     ge;
	logic [GIW-1:0]           gint;
	logic [GW-1:0]            gbase;
	logic [GW-1:0]            gpos;
	logic                     offa;
	logic                     offb;
	logic signed [SW-1:0]     wsum;
	logic [COORD_W-1:0]       wsat;
	logic [3:0]               vslot;
	logic                     is_last;
	logic                     emit_ok;
	logic [OUT_DATA_W-1:0]    packed_vert;

	always_comb begin
		vidx      = 4'({1'b0, tri_q}) * 4'd3 + 4'({2'b00, vtx_q});
		edge_code = tri_edge(head.ci, vidx);
		edge_sel  = (edge_code < 4'd12) ? edge_code : 4'd0;
		ca        = EDGE_A[edge_sel];
		cb        = EDGE_B[edge_sel];
		da        = head.dens[ca];
		db        = head.dens[cb];

		rem2 = {rem_q[DENS_W:0], 1'b0};
		ge   = rem2 >= {1'b0, dm_q};

		offa  = CORNER_OFF[ca_q][axis_q];
		offb  = CORNER_OFF[cb_q][axis_q];
		gint  = {1'b0, head.cube[axis_q]} + GIW'(offa);
		gbase = {gint, {FRAC_BITS{1'b0}}};
		if (offb && !offa) begin
			gpos = gbase + GW'(q_q);
		end else if (offa && !offb) begin
			gpos = gbase - GW'(q_q);
		end else begin
			gpos = gbase;
		end

		wsum = SW'($signed(cfg.origin[axis_q])) + $signed(SW'(phi_q)) +
			$signed(SW'(plo_q[PLW-1:FRAC_BITS]));
		if (wsum > SAT_HI) begin
			wsat = 32'h7fffffff;
		end else if (wsum < SAT_LO) begin
			wsat = 32'h80000000;
		end else begin
			wsat = wsum[COORD_W-1:0];
		end
		vslot = 4'({2'b00, vtx_q}) * 4'd3 + 4'({2'b00, axis_q});

		for (int i = 0; i < 9; i++) begin
			packed_vert[COORD_W*i +: COORD_W] = vert_q[i];
		end
		is_last = tri_q == head.ntri - NTRI_W'(1);
		emit_ok = emit_pending_q && (!out_valid_q || m_tready);
	end

	assign pop      = emit_ok && is_last;
	assign m_tvalid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			tri_q          <= '0;
			vtx_q          <= '0;
			axis_q         <= '0;
			cnt_q          <= '0;
			out_valid_q    <= 1'b0;
			emit_pending_q <= 1'b0;
		end else begin
			if (emit_ok) begin
				out_valid_q    <= 1'b1;
				m_tdata        <= packed_vert;
				m_tlast        <= is_last;
				emit_pending_q <= 1'b0;
				if (is_last) begin
					state_q <= ST_IDLE;
				end else begin
					tri_q   <= tri_q + NTRI_W'(1);
					vtx_q   <= '0;
					state_q <= ST_SETUP;
				end
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (nonempty && !emit_pending_q) begin
						tri_q   <= '0;
						vtx_q   <= '0;
						state_q <= ST_SETUP;
					end
				end
				ST_SETUP: begin
					if (!emit_pending_q) begin
						ca_q    <= ca;
						cb_q    <= cb;
						num_q   <= {cfg.iso[DENS_W-1], cfg.iso} - {da[DENS_W-1], da};
						den_q   <= {db[DENS_W-1], db} - {da[DENS_W-1], da};
						state_q <= ST_ABS;
					end
				end
				ST_ABS: begin
					nm_q    <= num_q[DENS_W] ? (DENS_W+1)'(-num_q) : num_q;
					dm_q    <= den_q[DENS_W] ? (DENS_W+1)'(-den_q) : den_q;
					state_q <= ST_DECIDE;
				end
				ST_DECIDE: begin
					axis_q <= '0;
					if (dm_q == '0) begin
						q_q     <= '0;
						state_q <= ST_GPOS;
					end else if (nm_q >= dm_q) begin
						// The crossing is at or past the far corner: clamp to one.
						q_q     <= ONE;
						state_q <= ST_GPOS;
					end else begin
						rem_q   <= {1'b0, nm_q};
						q_q     <= '0;
						cnt_q   <= '0;
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					rem_q <= ge ? rem2 - {1'b0, dm_q} : rem2;
					q_q   <= {q_q[FRAC_BITS-1:0], ge};
					cnt_q <= cnt_q + CW'(1);
					if (cnt_q == CW'(FRAC_BITS - 1)) begin
						state_q <= ST_GPOS;
					end
				end
				ST_GPOS: begin
					g_q     <= gpos;
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					phi_q   <= cfg.spacing * g_q[GW-1:FRAC_BITS];
					plo_q   <= cfg.spacing * g_q[FRAC_BITS-1:0];
					state_q <= ST_ADD;
				end
				ST_ADD: begin
					vert_q[vslot] <= wsat;
					if (axis_q != 2'd2) begin
						axis_q  <= axis_q + 2'd1;
						state_q <= ST_GPOS;
					end else if (vtx_q != 2'd2) begin
						vtx_q   <= vtx_q + 2'd1;
						state_q <= ST_SETUP;
					end else begin
						emit_pending_q <= 1'b1;
						state_q        <= ST_SETUP;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	a_pop_with_emit: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> emit_pending_q && nonempty)
		else $error("cube retired without a finished triangle");

	a_pop_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> state_q == ST_IDLE)
		else $error("back end kept working after the last triangle");

	a_frac_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_GPOS |-> q_q <= ONE)
		else $error("edge fraction above one");

	a_tri_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> (nonempty && tri_q < head.ntri))
		else $error("triangle counter ran past the case");

endmodule

### design/marching_cubes_cell_triangulator.sv
// Top level of the marching-cubes cell triangulator: configuration registers and the
// front end, queue and back end. Depends on mcct_pkg, mcct_front, mcct_queue, mcct_back.
//
// Each accepted cube request yields zero to five triangle results, the last one marked
// by tlast. Cubes outside the grid or with no crossing yield nothing.
// A two-entry queue lets new cubes be classified while earlier ones are worked on.
// The back end handles one vertex at a time through a shared restoring divider of
// FRAC_BITS steps; the divider is skipped when the edge fraction is clamped.
module marching_cubes_cell_triangulator import mcct_pkg::*; #(
	parameter int GRID_NODES_MAX = GRID_NODES_MAX_DEF,
	parameter int FRAC_BITS      = FRAC_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   wr_en,
	input  logic [CFG_IDX_W-1:0]   wr_index,
	input  logic [CFG_DATA_W-1:0]  wr_data,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [IN_DATA_W-1:0]   s_tdata,  // cube_x, cube_y, cube_z, density_c0..c7, pad
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_DATA_W-1:0]  m_tdata,  // vert_a_x,a_y,a_z,b_x,b_y,b_z,c_x,c_y,c_z
	output logic                   m_tlast   // last_triangle
);

	cfg_t   cfg_q;
	logic   push;
	logic   pop;
	logic   full;
	logic   nonempty;
	entry_t wr_entry;
	entry_t head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.iso     <= 32'sd65536;
			cfg_q.origin  <= '0;
			cfg_q.spacing <= 31'd65536;
			cfg_q.nodes   <= {3{9'd256}};
		end else if (wr_en) begin
			case (cfg_reg_t'(wr_index))
				REG_ISO_LEVEL: cfg_q.iso       <= wr_data;
				REG_ORIGIN_X:  cfg_q.origin[0] <= wr_data;
				REG_ORIGIN_Y:  cfg_q.origin[1] <= wr_data;
				REG_ORIGIN_Z:  cfg_q.origin[2] <= wr_data;
				REG_SPACING:   cfg_q.spacing   <= wr_data[SPACING_W-1:0];
				REG_NODES_X:   cfg_q.nodes[0]  <= wr_data[NODES_W-1:0];
				REG_NODES_Y:   cfg_q.nodes[1]  <= wr_data[NODES_W-1:0];
				REG_NODES_Z:   cfg_q.nodes[2]  <= wr_data[NODES_W-1:0];
				default:       cfg_q.iso       <= cfg_q.iso;
			endcase
		end
	end

	mcct_front #(
		.GRID_NODES_MAX(GRID_NODES_MAX)
	) u_front (
		.cfg      (cfg_q),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.full     (full),
		.push     (push),
		.entry    (wr_entry)
	);

	mcct_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wr_entry (wr_entry),
		.pop      (pop),
		.full     (full),
		.nonempty (nonempty),
		.head     (head)
	);

	mcct_back #(
		.FRAC_BITS(FRAC_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.nonempty (nonempty),
		.head     (head),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

endmodule

### dv/marching_cubes_cell_triangulator_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the marching-cubes cell triangulator: drives cube requests,
// predicts every triangle in a local fixed-point model and compares field by field.
// Depends on mcct_pkg and the marching_cubes_cell_triangulator top level.
module marching_cubes_cell_triangulator_tb;
	import mcct_pkg::*;

	localparam int FRAC = 16;
	localparam int NODES_CAP = 256;
	localparam longint CYCLE_LIMIT = 3000000;

	typedef struct {
		logic signed [31:0] v [9];
		logic last;
	} tri_t;

	typedef struct {
		logic signed [8:0] cx, cy, cz;
		logic signed [31:0] d [8];
		int ntri;   // -1: no fixed expectation, use the predictor
	} cube_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic wr_en = 1'b0;
	logic [CFG_IDX_W-1:0] wr_index = '0;
	logic [CFG_DATA_W-1:0] wr_data = '0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [IN_DATA_W-1:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic m_tlast;

	marching_cubes_cell_triangulator u_top (
		.clk(clk), .arst_n(arst_n), .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
	);

	always #10 clk = ~clk;

	// Local copy of the registers.
	logic signed [31:0] iso_q;
	logic signed [31:0] org_q [3];
	logic [30:0] spacing_q;
	logic [8:0] nodes_q [3];

	tri_t expected_tris [$];
	int mismatches = 0;
	longint cycles = 0;
	int send_idle_pct = 24, recv_idle_pct = 72;
	int hold_cycles = 0;

	// Corner offsets as x,y,z and edge end corners.
	const int COFF [8][3] = '{'{0,0,0},'{1,0,0},'{1,1,0},'{0,1,0},
		'{0,0,1},'{1,0,1},'{1,1,1},'{0,1,1}};
	const int EA [12] = '{0,1,2,3,4,5,6,7,0,1,2,3};
	const int EB [12] = '{1,2,3,0,5,6,7,4,4,5,6,7};

	// Lowest 9 + 9 + 9 + 8*32 bits, cube_x first.
	function automatic logic [IN_DATA_W-1:0] pack_cube(cube_row_t c);
		logic [IN_DATA_W-1:0] r;
		r = '0;
		r[8:0] = c.cx;
		r[17:9] = c.cy;
		r[26:18] = c.cz;
		for (int k = 0; k < 8; k++) r[27 + 32*k +: 32] = c.d[k];
		return r;
	endfunction

	function automatic logic signed [31:0] sat32(longint w);
		if (w > 64'sd2147483647) return 32'sh7fffffff;
		if (w < -64'sd2147483648) return 32'sh80000000;
		return w[31:0];
	endfunction

	function automatic void crossing_point(int cube [3], longint dens [8], int edge_id,
			output logic signed [31:0] o [3]);
		int a, b;
		longint num, den, nm, dm, t, g, w;
		longint unsigned sp;
		a = EA[edge_id];
		b = EB[edge_id];
		num = longint'(iso_q) - dens[a];
		den = dens[b] - dens[a];
		nm = num < 0 ? -num : num;
		dm = den < 0 ? -den : den;
		t = (dm == 0) ? 0 : (nm <<< FRAC) / dm;
		if (t > (64'sd1 <<< FRAC)) t = 64'sd1 <<< FRAC;
		sp = spacing_q;
		for (int k = 0; k < 3; k++) begin
			g = longint'(cube[k] + COFF[a][k]) <<< FRAC;
			if (COFF[b][k] > COFF[a][k]) g += t;
			else if (COFF[b][k] < COFF[a][k]) g -= t;
			// g is never negative here, so shifts match floor division.
			w = longint'(org_q[k]) + longint'(sp * (g >> FRAC))
				+ longint'((sp * (g & ((64'sd1 <<< FRAC) - 1))) >> FRAC);
			o[k] = sat32(w);
		end
	endfunction

	// Queues the triangles of one cube; returns how many.
	function automatic int predict_triangles(cube_row_t c);
		int cube [3];
		longint dens [8];
		logic [7:0] ci;
		int ntri, n, e;
		logic [62:0] row;
		tri_t tr;
		logic signed [31:0] p [3];
		cube[0] = c.cx; cube[1] = c.cy; cube[2] = c.cz;
		for (int k = 0; k < 3; k++) begin
			n = nodes_q[k] > NODES_CAP ? NODES_CAP : nodes_q[k];
			if (cube[k] < 0 || cube[k] >= n - 1) return 0;
		end
		ci = '0;
		for (int k = 0; k < 8; k++) begin
			dens[k] = c.d[k];
			if (c.d[k] < iso_q) ci[k] = 1'b1;
		end
		row = TRI_TAB[ci];
		ntri = int'(row[62:60]);
		for (int i = 0; i < ntri; i++) begin
			for (int v = 0; v < 3; v++) begin
				e = row[4*(3*ntri - 1 - (3*i + v)) +: 4];
				crossing_point(cube, dens, e, p);
				for (int k = 0; k < 3; k++) tr.v[3*v + k] = p[k];
			end
			tr.last = (i == ntri - 1);
			expected_tris = {expected_tris, tr};
		end
		return ntri;
	endfunction

	// Result checking and receiver stall.
	always @(posedge clk) begin
		tri_t e;
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_tris.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected triangle %h", m_tdata);
			end else begin
				e = expected_tris.pop_front();
				for (int k = 0; k < 9; k++)
					if (m_tdata[32*k +: 32] !== e.v[k]) begin
						mismatches++;
						if (mismatches <= 10)
							$display("coord %0d: expected %0d got %0d", k, e.v[k],
								$signed(m_tdata[32*k +: 32]));
					end
				if (m_tlast !== e.last) begin
					mismatches++;
					if (mismatches <= 10)
						$display("last flag: expected %b got %b", e.last, m_tlast);
				end
			end
		end
		if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			m_tready <= 1'b0;
		end else
			m_tready <= ($urandom_range(99) >= recv_idle_pct);
	end

	task automatic write_reg(cfg_reg_t idx, logic [31:0] val);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= val;
		@(posedge clk);
		wr_en <= 1'b0;
		case (idx)
			REG_ISO_LEVEL: iso_q = val;
			REG_ORIGIN_X: org_q[0] = val;
			REG_ORIGIN_Y: org_q[1] = val;
			REG_ORIGIN_Z: org_q[2] = val;
			REG_SPACING: spacing_q = val[30:0];
			REG_NODES_X: nodes_q[0] = val[8:0];
			REG_NODES_Y: nodes_q[1] = val[8:0];
			default: nodes_q[2] = val[8:0];
		endcase
		@(posedge clk);
	endtask

	// Offers one cube with random gaps, predicting at acceptance.
	task automatic send_cube(cube_row_t c);
		int n;
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= pack_cube(c);
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		n = predict_triangles(c);
		if (c.ntri >= 0 && n != c.ntri) begin
			mismatches++;
			if (mismatches <= 10) $display("case count: expected %0d got %0d", c.ntri, n);
		end
	endtask

	// Waits for the queue to drain, then long enough for the block to be idle.
	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (expected_tris.size() != 0) @(posedge clk);
		repeat (600) @(posedge clk);
	endtask

	function automatic cube_row_t uniform_cube(int lo, int hi, logic signed [31:0] val);
		cube_row_t c;
		c.cx = 9'(lo); c.cy = 9'(lo); c.cz = 9'(hi);
		for (int k = 0; k < 8; k++) c.d[k] = val;
		c.ntri = -1;
		return c;
	endfunction

	function automatic cube_row_t random_cube(int span, logic signed [31:0] iso);
		cube_row_t c;
		int m;
		m = $urandom_range(9);
		c.cx = 9'($urandom_range(span));
		c.cy = 9'($urandom_range(span));
		c.cz = 9'($urandom_range(span));
		if (m == 0) begin
			c.cx = 9'($urandom); c.cy = 9'($urandom); c.cz = 9'($urandom);
		end
		for (int k = 0; k < 8; k++) begin
			if (m == 1) c.d[k] = $urandom;
			else c.d[k] = iso + $signed($urandom_range(8 << FRAC)) - (4 << FRAC);
		end
		c.ntri = -1;
		return c;
	endfunction

	cube_row_t directed [$];

	initial begin
		cube_row_t c;
		iso_q = 32'sd65536;
		org_q = '{0, 0, 0};
		spacing_q = 31'd65536;
		nodes_q = '{256, 256, 256};
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table: empty cases, one corner below, out-of-grid cubes, extremes.
		c = uniform_cube(0, 0, 32'sd0);        c.ntri = 0; directed = {directed, c};
		c = uniform_cube(0, 0, 32'sh7fffffff); c.ntri = 0; directed = {directed, c};
		c = uniform_cube(3, 4, 32'sh7fffffff); c.d[0] = 32'sh80000000; c.ntri = 1;
		directed = {directed, c};
		c = uniform_cube(254, 254, 32'sh80000000); c.d[6] = 32'sh7fffffff; c.ntri = 1;
		directed = {directed, c};
		c = uniform_cube(255, 0, 32'sd0); c.d[3] = 32'sd200000; c.ntri = 0;
		directed = {directed, c};
		c = uniform_cube(-1, 0, 32'sd0); c.d[3] = 32'sd200000; c.ntri = 0;
		directed = {directed, c};
		c = uniform_cube(-256, 5, 32'sd0); c.ntri = 0; directed = {directed, c};
		c = uniform_cube(1, 2, 32'sd131072); c.d[0] = 32'sd0; c.d[2] = 32'sd0;
		c.d[5] = 32'sd0; c.d[7] = 32'sd0; c.ntri = 4; directed = {directed, c};
		// Corner exactly at the threshold counts as not below.
		c = uniform_cube(7, 7, 32'sd65536); c.d[1] = 32'sd65535; c.ntri = 1;
		directed = {directed, c};
		for (int i = 0; i < 8; i++) begin
			c = uniform_cube(i, 9 - i, 32'sd0);
			c.d[i] = 32'sd300000;
			c.ntri = 1;
			directed = {directed, c};
		end
		// A five-triangle case.
		c = uniform_cube(10, 10, 32'sd0); c.d[0] = 32'sd200000; c.d[2] = 32'sd200000;
		c.d[7] = 32'sd200000; c.d[1] = 32'sd0; c.ntri = -1; directed = {directed, c};
		foreach (directed[i]) send_cube(directed[i]);
		drain_results();

		// Configuration phases with random cubes in each.
		for (int ph = 0; ph < 5; ph++) begin
			logic signed [31:0] iso;
			int span;
			case (ph)
				0: begin
					iso = 32'sh80000000;
					write_reg(REG_ISO_LEVEL, iso);
					write_reg(REG_NODES_X, 9'd2);
					write_reg(REG_NODES_Y, 9'd3);
					write_reg(REG_NODES_Z, 9'd511);
				end
				1: begin
					iso = 32'sh7fffffff - (5 << FRAC);
					write_reg(REG_ISO_LEVEL, iso);
					write_reg(REG_ORIGIN_X, 32'sh7fff0000);
					write_reg(REG_ORIGIN_Y, 32'sh80000000);
					write_reg(REG_ORIGIN_Z, 32'hffffffff);
					write_reg(REG_SPACING, 32'h7fffffff);
					write_reg(REG_NODES_X, 9'd6);
					write_reg(REG_NODES_Y, 9'd6);
					write_reg(REG_NODES_Z, 9'd6);
				end
				2: begin
					iso = $urandom;
					iso = iso >>> 2;
					write_reg(REG_ISO_LEVEL, iso);
					write_reg(REG_ORIGIN_X, $urandom);
					write_reg(REG_ORIGIN_Y, $urandom);
					write_reg(REG_ORIGIN_Z, $urandom);
					write_reg(REG_SPACING, 32'd1);
					write_reg(REG_NODES_X, 9'd1);
				end
				3: begin
					send_idle_pct = 72;
					recv_idle_pct = 24;
					iso = 32'sd0;
					write_reg(REG_ISO_LEVEL, iso);
					write_reg(REG_SPACING, 32'h80000000);
					write_reg(REG_NODES_X, 9'd256);
					write_reg(REG_NODES_Y, 9'd256);
					write_reg(REG_NODES_Z, 9'd256);
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
					iso = 32'sd65536;
					write_reg(REG_ISO_LEVEL, iso);
					write_reg(REG_ORIGIN_X, 32'sd0);
					write_reg(REG_ORIGIN_Y, 32'sd0);
					write_reg(REG_ORIGIN_Z, 32'sd0);
					write_reg(REG_SPACING, 32'd65536);
				end
			endcase
			span = (ph == 1) ? 6 : (ph == 0 ? 3 : 255);
			// Long output stall so the queue fills and input backs up.
			if (ph == 3) hold_cycles = 3000;
			for (int i = 0; i < 32; i++) send_cube(random_cube(span, iso));
			drain_results();
		end

		if (mismatches == 0 && expected_tris.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end
endmodule

### files.f
design/mcct_pkg.sv
design/mcct_front.sv
design/mcct_queue.sv
design/mcct_back.sv
design/marching_cubes_cell_triangulator.sv
dv/marching_cubes_cell_triangulator_tb.sv
